@@ hw/rtl/epoch_seconds_to_calendar_assert.svh @@
// assertion macros for the epoch to calendar converter
`ifndef EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_ASSERT_SVH
`ifndef SYNTHESIS
`define EPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
	else $error("epc invariant violated");
`define EPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("epc implication violated");
`else
`define EPC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define EPC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/epc_pkg.sv @@
// shared types, constants and tables of the epoch to calendar converter
package epc_pkg;

	typedef struct packed {
		logic valid;
		logic err;
	} epc_ctl_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} epc_hms_t;

	// accept-to-strobe latency in cycles
	localparam int EPC_LATENCY = 11;

	// supported input span and biases
	localparam logic signed [38:0] IN_LOW     = -39'sd211813488000;
	localparam logic signed [38:0] IN_HIGH    = 39'sd252455529599;
	localparam logic [38:0]        U_BIAS     = 39'd211813531200;
	localparam logic signed [38:0] GPS_OFFSET = 39'sd630763200;

	// day split: (u >> 7) / 675
	localparam logic [9:0]  DZ_DIV   = 10'd675;
	localparam int          DZ_SHIFT = 42;
	localparam logic [32:0] DZ_MUL   =
		33'(((64'd1 << DZ_SHIFT) + 64'd674) / 64'd675);

	// gregorian correction
	localparam logic [22:0] SWITCH_DAY  = 23'd2299161;
	localparam logic [24:0] ALPHA_OFS   = 25'd7468865;
	localparam int          ALPHA_SHIFT = 42;
	localparam logic [24:0] ALPHA_MUL   =
		25'(((64'd1 << ALPHA_SHIFT) + 64'd146096) / 64'd146097);
	localparam logic [22:0] B_BIAS      = 23'd1524;

	// year count c = (100 b - 12210) / 36525
	localparam logic [29:0] C_SCALE = 30'd100;
	localparam logic [29:0] C_OFS   = 30'd12210;
	localparam int          C_SHIFT = 46;
	localparam logic [30:0] C_MUL   =
		31'(((64'd1 << C_SHIFT) + 64'd36524) / 64'd36525);
	localparam logic [25:0] D_MUL   = 26'd1461;

	// month index e = (bd * 10000) / 306001, scale folded into the multiplier
	localparam int          E_SHIFT = 42;
	localparam logic [23:0] E_RECIP =
		24'(((64'd1 << E_SHIFT) + 64'd306000) / 64'd306001);
	localparam logic [37:0] E_MUL   = 38'(64'd10000 * 64'(E_RECIP));

	localparam logic [4:0]  MON_SPLIT  = 5'd14;
	localparam logic [4:0]  MON_OFS_LO = 5'd1;
	localparam logic [4:0]  MON_OFS_HI = 5'd13;
	localparam logic [15:0] YR_OFS_LO  = 16'd4716;
	localparam logic [15:0] YR_OFS_HI  = 16'd4715;

	// time of day
	localparam int          H_SHIFT      = 29;
	localparam logic [17:0] H_MUL        =
		18'(((64'd1 << H_SHIFT) + 64'd3599) / 64'd3600);
	localparam int          M_SHIFT      = 23;
	localparam logic [17:0] M_MUL        =
		18'(((64'd1 << M_SHIFT) + 64'd59) / 64'd60);
	localparam logic [10:0] MIN_PER_HOUR = 11'd60;
	localparam logic [16:0] SEC_PER_MIN  = 17'd60;

	// gps: rollover = (|g| >> 17) / 4725, week = (rem >> 7) / 4725
	localparam int          R_SHIFT  = 34;
	localparam logic [21:0] R_MUL    =
		22'(((64'd1 << R_SHIFT) + 64'd4724) / 64'd4725);
	localparam logic [37:0] ROLL_SEC = 38'd619315200;
	localparam int          W_SHIFT  = 36;
	localparam logic [23:0] W_MUL    =
		24'(((64'd1 << W_SHIFT) + 64'd4724) / 64'd4725);
	localparam logic [29:0] WEEK_SEC = 30'd604800;

	// days before month index e: floor(30.6001 e)
	function automatic logic [8:0] month_start(input logic [4:0] e);
		logic [8:0] r;
		unique case (e)
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ hw/rtl/epoch_seconds_to_calendar.sv @@
// top level: seconds since j2000 to calendar date, time of day and gps time
//
// channel | ports                                  | transfer
// --------+----------------------------------------+------------------------------------
// input   | start, busy, seconds_since_epoch       | beat taken when start high, busy low
// result  | done, year .. gps_second, range_error  | one-cycle done strobe, no hold-off
//
// a new beat can be taken every cycle; busy stays low
// each result is set by the date chain depth: it follows its beat through the
// input and range stages, the day split, then the chain of multiplies in series
// the gps lane runs alongside and lines up with the date lane at the output
// reset clears only the valid and err bits; beats in flight are dropped
// the receiver cannot stall, so the pipeline advances every cycle
`include "epoch_seconds_to_calendar_assert.svh"

module epoch_seconds_to_calendar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [38:0] seconds_since_epoch,
	output logic               done,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second_of_minute,
	output logic signed [9:0]  gps_rollover,
	output logic signed [10:0] gps_week,
	output logic signed [20:0] gps_second,
	output logic               range_error
);
	import epc_pkg::*;

	logic               v_s1;
	logic signed [38:0] s_s1;
	epc_ctl_t           ctl_s2;
	logic [38:0]        u_s2;
	logic signed [38:0] g_s2;

	epc_ctl_t    day_ctl;
	logic [22:0] day_z;
	logic [16:0] day_sod;
	epc_ctl_t    cal_ctl;
	epc_ctl_t    gps_ctl;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			ctl_s2 <= '0;
		end else begin
			v_s1         <= start && !busy;
			ctl_s2.valid <= v_s1;
			ctl_s2.err   <= (s_s1 < IN_LOW) || (s_s1 > IN_HIGH);
		end
	end

	// u counts seconds from midnight starting day zero
	always_ff @(posedge clk) begin
		s_s1 <= seconds_since_epoch;
		u_s2 <= $unsigned(s_s1) + U_BIAS;
		g_s2 <= s_s1 + GPS_OFFSET;
	end

	epc_day u_day (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s2),
		.u       (u_s2),
		.ctl_out (day_ctl),
		.z       (day_z),
		.sod     (day_sod)
	);

	epc_cal u_cal (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctl_in           (day_ctl),
		.z                (day_z),
		.sod              (day_sod),
		.ctl_out          (cal_ctl),
		.year             (year),
		.month            (month),
		.day              (day),
		.hour             (hour),
		.minute           (minute),
		.second_of_minute (second_of_minute)
	);

	epc_gps u_gps (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl_in         (ctl_s2),
		.g              (g_s2),
		.ctl_out        (gps_ctl),
		.rollover       (gps_rollover),
		.week           (gps_week),
		.second_of_week (gps_second)
	);

	assign done        = cal_ctl.valid;
	assign range_error = cal_ctl.err;

	`EPC_ASSERT_ALWAYS(a_lanes_aligned, clk, arst_n, gps_ctl == cal_ctl)
	`EPC_ASSERT_IMPLY(a_latency, clk, arst_n, done, $past(start && !busy, EPC_LATENCY))
	`EPC_ASSERT_IMPLY(a_err_clears, clk, arst_n, done && range_error, year == 15'sd0 && month == 4'd0 && day == 5'd0 && hour == 5'd0 && gps_rollover == 10'sd0 && gps_week == 11'sd0 && gps_second == 21'sd0)
	`EPC_ASSERT_IMPLY(a_date_sane, clk, arst_n, done && !range_error, month != 4'd0 && month <= 4'd12 && day != 5'd0 && hour <= 5'd23)

endmodule

@@ hw/rtl/epc_day.sv @@
// two-stage split of seconds since day zero into day number and second of day
module epc_day (
	input  logic              clk,
	input  logic              arst_n,
	input  epc_pkg::epc_ctl_t ctl_in,
	input  logic [38:0]       u,
	output epc_pkg::epc_ctl_t ctl_out,
	output logic [22:0]       z,
	output logic [16:0]       sod
);
	import epc_pkg::*;

	epc_ctl_t    ctl_s1, ctl_s2;
	logic [64:0] prod_s1;
	logic [31:0] x_s1;
	logic [6:0]  low_s1;
	logic [22:0] z_s2;
	logic [16:0] sod_s2;

	logic [22:0] zq;
	logic [31:0] zd;
	logic [31:0] rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	// 86400 = 128 * 675, so the low seven bits pass straight into the remainder
	always_comb begin
		zq  = prod_s1[64:DZ_SHIFT];
		zd  = 32'(zq) * 32'(DZ_DIV);
		rem = x_s1 - zd;
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 65'(u[38:7]) * 65'(DZ_MUL);
		x_s1    <= u[38:7];
		low_s1  <= u[6:0];
		z_s2    <= zq;
		sod_s2  <= {rem[9:0], low_s1};
	end

	assign ctl_out = ctl_s2;
	assign z       = z_s2;
	assign sod     = sod_s2;

endmodule

@@ hw/rtl/epc_cal.sv @@
// seven-stage day number to calendar date and time of day pipeline
module epc_cal (
	input  logic               clk,
	input  logic               arst_n,
	input  epc_pkg::epc_ctl_t  ctl_in,
	input  logic [22:0]        z,
	input  logic [16:0]        sod,
	output epc_pkg::epc_ctl_t  ctl_out,
	output logic signed [14:0] year,
	output logic [3:0]         month,
	output logic [4:0]         day,
	output logic [4:0]         hour,
	output logic [5:0]         minute,
	output logic [5:0]         second_of_minute
);
	import epc_pkg::*;

	epc_ctl_t    ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic [48:0] pa_s1;
	logic [22:0] z_s1;
	logic        sw_s1;
	logic [34:0] ph_s1, pm_s1;
	logic [16:0] sod_s1;
	logic [22:0] b_s2, b_s3, b_s4;
	epc_hms_t    hms_s2, hms_s3, hms_s4, hms_s5, hms_s6, hms_s7;
	logic [29:0] numc_s3;
	logic [60:0] pc_s4;
	logic [14:0] c_s5, c_s6;
	logic [8:0]  bd_s5, bd_s6;
	logic [46:0] pe_s6;
	logic [14:0] year_s7;
	logic [3:0]  month_s7;
	logic [4:0]  day_s7;

	logic [24:0] num_a;
	logic [6:0]  alpha;
	logic [22:0] a;
	logic [4:0]  hr;
	logic [10:0] mt;
	logic [10:0] hm;
	logic [16:0] ms;
	epc_hms_t    hms_new;
	logic [14:0] c;
	logic [25:0] cd;
	logic [22:0] bd_full;
	logic [4:0]  e;
	logic        early;
	logic [8:0]  dom;
	logic [4:0]  mon;
	logic [15:0] yr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
		end
	end

	always_comb begin
		// only meaningful past the calendar switch, selected off below it
		num_a = {z, 2'b00} - ALPHA_OFS;

		alpha = pa_s1[48:ALPHA_SHIFT];
		a     = sw_s1 ? (z_s1 + 23'd1 + 23'(alpha) - 23'(alpha[6:2])) : z_s1;

		hr     = ph_s1[33:H_SHIFT];
		mt     = pm_s1[33:M_SHIFT];
		hm     = 11'(hr) * MIN_PER_HOUR;
		ms     = 17'(mt) * SEC_PER_MIN;
		hms_new.hour   = hr;
		hms_new.minute = 6'(mt - hm);
		hms_new.second = 6'(sod_s1 - ms);

		c       = pc_s4[60:C_SHIFT];
		cd      = 26'(c) * D_MUL;
		bd_full = b_s4 - cd[24:2];

		e     = pe_s6[46:E_SHIFT];
		early = (e < MON_SPLIT);
		dom   = bd_s6 - month_start(e);
		mon   = early ? (e - MON_OFS_LO) : (e - MON_OFS_HI);
		yr    = {1'b0, c_s6} - (early ? YR_OFS_LO : YR_OFS_HI);
	end

	always_ff @(posedge clk) begin
		pa_s1  <= 49'(num_a[23:0]) * 49'(ALPHA_MUL);
		z_s1   <= z;
		sw_s1  <= (z >= SWITCH_DAY);
		ph_s1  <= 35'(sod) * 35'(H_MUL);
		pm_s1  <= 35'(sod) * 35'(M_MUL);
		sod_s1 <= sod;

		b_s2   <= a + B_BIAS;
		hms_s2 <= hms_new;

		numc_s3 <= 30'(b_s2) * C_SCALE - C_OFS;
		b_s3    <= b_s2;
		hms_s3  <= hms_s2;

		pc_s4  <= 61'(numc_s3) * 61'(C_MUL);
		b_s4   <= b_s3;
		hms_s4 <= hms_s3;

		c_s5   <= c;
		bd_s5  <= bd_full[8:0];
		hms_s5 <= hms_s4;

		pe_s6  <= 47'(bd_s5) * 47'(E_MUL);
		c_s6   <= c_s5;
		bd_s6  <= bd_s5;
		hms_s6 <= hms_s5;

		// out of range beats leave with every field cleared
		if (ctl_s6.err) begin
			year_s7  <= '0;
			month_s7 <= '0;
			day_s7   <= '0;
			hms_s7   <= '0;
		end else begin
			year_s7  <= yr[14:0];
			month_s7 <= mon[3:0];
			day_s7   <= dom[4:0];
			hms_s7   <= hms_s6;
		end
	end

	assign ctl_out          = ctl_s7;
	assign year             = $signed(year_s7);
	assign month            = month_s7;
	assign day              = day_s7;
	assign hour             = hms_s7.hour;
	assign minute           = hms_s7.minute;
	assign second_of_minute = hms_s7.second;

endmodule

@@ hw/rtl/epc_gps.sv @@
// nine-stage gps rollover, week and second of week pipeline
module epc_gps (
	input  logic               clk,
	input  logic               arst_n,
	input  epc_pkg::epc_ctl_t  ctl_in,
	input  logic signed [38:0] g,
	output epc_pkg::epc_ctl_t  ctl_out,
	output logic signed [9:0]  rollover,
	output logic signed [10:0] week,
	output logic signed [20:0] second_of_week
);
	import epc_pkg::*;

	epc_ctl_t    ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [37:0] gabs_s1, gabs_s2, gabs_s3;
	logic [42:0] pr_s2;
	logic [8:0]  roll_s3, roll_s4, roll_s5, roll_s6, roll_s7;
	logic [37:0] rprod_s3;
	logic [29:0] rem_s4, rem_s5, rem_s6;
	logic [46:0] pw_s5;
	logic [9:0]  week_s6, week_s7;
	logic [29:0] wprod_s6;
	logic [19:0] gsec_s7;
	logic [9:0]  roll_s8, roll_s9;
	logic [10:0] week_s8, week_s9;
	logic [20:0] gsec_s8, gsec_s9;

	logic [38:0] gn;
	logic [8:0]  roll_q0;
	logic [37:0] rem_full;
	logic [9:0]  week_q0;
	logic [29:0] gsec_full;
	logic [9:0]  roll_x;
	logic [10:0] week_x;
	logic [20:0] gsec_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	// divide the magnitude, then put the sign back: truncation toward zero
	always_comb begin
		gn        = -g;
		roll_q0   = pr_s2[42:R_SHIFT];
		rem_full  = gabs_s3 - rprod_s3;
		week_q0   = pw_s5[45:W_SHIFT];
		gsec_full = rem_s6 - wprod_s6;
		roll_x    = {1'b0, roll_s7};
		week_x    = {1'b0, week_s7};
		gsec_x    = {1'b0, gsec_s7};
	end

	always_ff @(posedge clk) begin
		neg_s1  <= g[38];
		gabs_s1 <= g[38] ? gn[37:0] : g[37:0];

		neg_s2  <= neg_s1;
		gabs_s2 <= gabs_s1;
		pr_s2   <= 43'(gabs_s1[37:17]) * 43'(R_MUL);

		neg_s3   <= neg_s2;
		gabs_s3  <= gabs_s2;
		roll_s3  <= roll_q0;
		rprod_s3 <= 38'(roll_q0) * ROLL_SEC;

		neg_s4  <= neg_s3;
		roll_s4 <= roll_s3;
		rem_s4  <= rem_full[29:0];

		neg_s5  <= neg_s4;
		roll_s5 <= roll_s4;
		rem_s5  <= rem_s4;
		pw_s5   <= 47'(rem_s4[29:7]) * 47'(W_MUL);

		neg_s6   <= neg_s5;
		roll_s6  <= roll_s5;
		rem_s6   <= rem_s5;
		week_s6  <= week_q0;
		wprod_s6 <= 30'(week_q0) * WEEK_SEC;

		neg_s7  <= neg_s6;
		roll_s7 <= roll_s6;
		week_s7 <= week_s6;
		gsec_s7 <= gsec_full[19:0];

		roll_s8 <= neg_s7 ? 10'(-roll_x) : roll_x;
		week_s8 <= neg_s7 ? 11'(-week_x) : week_x;
		gsec_s8 <= neg_s7 ? 21'(-gsec_x) : gsec_x;

		if (ctl_s8.err) begin
			roll_s9 <= '0;
			week_s9 <= '0;
			gsec_s9 <= '0;
		end else begin
			roll_s9 <= roll_s8;
			week_s9 <= week_s8;
			gsec_s9 <= gsec_s8;
		end
	end

	assign ctl_out        = ctl_s9;
	assign rollover       = $signed(roll_s9);
	assign week           = $signed(week_s9);
	assign second_of_week = $signed(gsec_s9);

endmodule
